// ----- rtl/mmes_pkg.sv -----
// ----------------------------------------------------------------------------
// mmes_pkg
// Shared types and sizing for the memory map entry sorter.
// ----------------------------------------------------------------------------
package mmes_pkg;

    // Capacity of the sorting chain, one entry per cell (range 2 to 64).
    localparam int MAX_ENTRIES = 32;

    localparam int ADDR_W = 64;
    localparam int LEN_W  = 64;
    localparam int TYPE_W = 32;

    typedef struct packed {
        logic [ADDR_W-1:0] base_address;
        logic [LEN_W-1:0]  region_length;
        logic [TYPE_W-1:0] region_type;
    } in_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] out_address;
        logic [LEN_W-1:0]  out_length;
        logic [TYPE_W-1:0] out_type;
        logic              final_entry;
        logic              overflowed;
    } out_req_t;

    // One stored memory map entry.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [TYPE_W-1:0] rtype;
    } entry_t;

    // What a cell shows to its neighbors.
    typedef struct packed {
        logic   occupied;
        entry_t entry;
    } cell_state_t;

    // Chain-wide command broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

endpackage

// ----- rtl/mmes_cell.sv -----
// ----------------------------------------------------------------------------
// mmes_cell
// One slot of the insertion chain: compares the incoming address with its
// own entry, shifts toward higher slots on insert, toward slot zero on drain.
// ----------------------------------------------------------------------------
module mmes_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mmes_pkg::cell_ctrl_t ctrl,
    input  mmes_pkg::entry_t     new_entry,
    input  mmes_pkg::cell_state_t left_state,
    input  logic                 left_shift,
    input  mmes_pkg::cell_state_t right_state,
    output mmes_pkg::cell_state_t state,
    output logic                 shift
);

    logic             occ_reg, occ_next;
    mmes_pkg::entry_t entry_reg, entry_next;

    // An empty slot always yields; an occupied one yields only to a strictly
    // lower address, which keeps equal addresses in arrival order.
    assign shift = !occ_reg || (new_entry.addr < entry_reg.addr);

    always_comb begin
        occ_next   = occ_reg;
        entry_next = entry_reg;
        if (ctrl.drain) begin
            occ_next   = right_state.occupied;
            entry_next = right_state.entry;
        end else if (ctrl.insert && shift) begin
            if (left_shift) begin
                occ_next   = left_state.occupied;
                entry_next = left_state.entry;
            end else begin
                occ_next   = 1'b1;
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
        entry_reg <= entry_next;
    end

    assign state.occupied = occ_reg;
    assign state.entry    = entry_reg;

endmodule

// ----- rtl/memory_map_entry_sorter_core.sv -----
// ----------------------------------------------------------------------------
// memory_map_entry_sorter_core
// Stable insertion sort of memory map entries in a chain of compare cells.
// ----------------------------------------------------------------------------
// One entry is taken per cycle while no run is unloading; after a terminator
// the stored entries leave at one result per cycle unless the output stalls,
// the chain shifting toward slot zero. An entry is stored at the edge it is
// accepted; the terminator sets the drain flag, which then loads slot zero
// into the output register. While a run drains, stalls included, no request
// is accepted. Reset (aresetn low, synchronous) empties the chain.
// ----------------------------------------------------------------------------
module memory_map_entry_sorter_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mmes_pkg::in_req_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mmes_pkg::out_req_t  m_data
);

    localparam int N = mmes_pkg::MAX_ENTRIES;

    // Chain signals. Index N is a permanently empty slot past the end.
    mmes_pkg::cell_state_t cell_state [N+1];
    logic [N-1:0]          cell_shift;
    logic [N-1:0]          occ_vec;
    mmes_pkg::cell_ctrl_t  ctrl;
    mmes_pkg::entry_t      new_entry;

    logic               drain_reg, drain_next;
    logic               dropped_reg, dropped_next;
    logic               m_valid_reg, m_valid_next;
    mmes_pkg::out_req_t m_data_reg, m_data_next;

    logic accept;
    logic is_term;
    logic full;
    logic load;

    assign new_entry.addr  = s_data.base_address;
    assign new_entry.len   = s_data.region_length;
    assign new_entry.rtype = s_data.region_type;

    // Requests are taken whenever the chain is not unloading a run.
    assign s_ready = !drain_reg;
    assign accept  = s_valid && s_ready;
    assign is_term = (s_data.region_length == '0);
    assign full    = occ_vec[N-1];

    // While a run unloads, the output register is refilled from slot zero when empty
    // or being taken, and the whole chain moves one slot down in the same cycle.
    assign load = drain_reg && (!m_valid_reg || m_ready);

    assign ctrl.insert = accept && !is_term && !full;
    assign ctrl.drain  = load;

    assign cell_state[N].occupied = 1'b0;
    assign cell_state[N].entry    = '0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        mmes_pkg::cell_state_t left_state;
        logic                  left_shift;

        if (i == 0) begin : g_head
            // Slot zero has nothing on its left, so it takes the new entry.
            assign left_state = '0;
            assign left_shift = 1'b0;
        end else begin : g_body
            assign left_state = cell_state[i-1];
            assign left_shift = cell_shift[i-1];
        end

        mmes_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_state  (left_state),
            .left_shift  (left_shift),
            .right_state (cell_state[i+1]),
            .state       (cell_state[i]),
            .shift       (cell_shift[i])
        );

        assign occ_vec[i] = cell_state[i].occupied;
    end

    // Run control: a terminator with a filled chain starts unloading; with an
    // empty chain it only clears the overflow mark. An entry arriving while
    // the chain is full is dropped and marks the run as overflowed.
    always_comb begin
        drain_next   = drain_reg;
        dropped_next = dropped_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (accept) begin
            if (is_term) begin
                if (occ_vec[0]) begin
                    drain_next = 1'b1;
                end else begin
                    dropped_next = 1'b0;
                end
            end else if (full) begin
                dropped_next = 1'b1;
            end
        end

        if (load) begin
            m_valid_next            = 1'b1;
            m_data_next.out_address = cell_state[0].entry.addr;
            m_data_next.out_length  = cell_state[0].entry.len;
            m_data_next.out_type    = cell_state[0].entry.rtype;
            m_data_next.final_entry = !cell_state[1].occupied;
            m_data_next.overflowed  = dropped_reg;
            if (!cell_state[1].occupied) begin
                // Last entry of the run leaves; the block is ready for a new list.
                drain_next   = 1'b0;
                dropped_next = 1'b0;
            end
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drain_reg   <= 1'b0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            drain_reg   <= drain_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Occupied slots always form one block starting at slot zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((occ_vec & (occ_vec + 1'b1)) == '0))
        else $error("chain occupancy is not contiguous from slot zero");

    // While a run unloads, slot zero still holds an entry to send.
    assert property (@(posedge aclk) disable iff (!aresetn)
        drain_reg |-> occ_vec[0])
        else $error("unloading with an empty head slot");

    // Sending the final entry empties the chain and ends the run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !cell_state[1].occupied) |=> (!drain_reg && !occ_vec[0] && !dropped_reg))
        else $error("chain not cleared after final entry");

    // An entry arriving at a full chain marks the run as overflowed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_term && full) |=> dropped_reg)
        else $error("dropped entry not recorded");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the memory map entry sorter core.
// ----------------------------------------------------------------------------
// Lists of memory map entries are sent one request at a time, each list closed
// by a zero-length terminator. A predictor in the bench keeps its own stable
// insertion sort of the current list. It queues the sorted run that every
// terminator should release, and each result is checked field by field
// against the oldest queued entry. A short table of directed requests comes
// first. Random lists follow: mostly short, some filling the store exactly,
// some running past it, and some terminators on an empty store. The sender
// idles in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_REQUESTS = 420;
    localparam int          CYCLE_LIMIT     = 200000;
    localparam logic [63:0] ALL_ONES_64     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] ALL_ONES_32     = 32'hFFFF_FFFF;

    // Receiver stall patterns. Each one holds for a random stretch of cycles.
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SLOW
    } rx_mode_t;

    // One row of the directed table. When known_result is set, the expected
    // outcome is typed into the row: either no result at all, or the single
    // result in typed_result when has_result is set. Otherwise the predictor
    // supplies the expected results.
    typedef struct packed {
        mmes_pkg::in_req_t  req;
        logic               known_result;
        logic               has_result;
        mmes_pkg::out_req_t typed_result;
    } directed_row_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    mmes_pkg::in_req_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    mmes_pkg::out_req_t m_data;

    // Predictor state: the entries of the list being built, kept in address
    // order, plus the count and the sticky drop flag.
    mmes_pkg::in_req_t  sorted_entries [mmes_pkg::MAX_ENTRIES];
    int                 sorted_count   = 0;
    logic               entries_dropped = 1'b0;

    // Sorted-run entries still waiting to come out of the block, oldest first.
    mmes_pkg::out_req_t pending_entries [$];

    int       error_count = 0;
    int       cycle_count = 0;
    int       burst_left  = 0;

    // Directed requests. The terminators that close single-entry lists have
    // their result typed in, as does the terminator on an empty store.
    directed_row_t directed_rows [0:22] = '{
        // Terminator on an empty store: nothing comes out.
        '{'{64'h0, 64'h0, 32'h0}, 1'b1, 1'b0, '0},
        // Largest values in every field; the terminator's address and type
        // are ignored.
        '{'{ALL_ONES_64, ALL_ONES_64, ALL_ONES_32}, 1'b0, 1'b0, '0},
        '{'{64'h1234, 64'h0, 32'hDEAD_BEEF}, 1'b1, 1'b1,
          '{ALL_ONES_64, ALL_ONES_64, ALL_ONES_32, 1'b1, 1'b0}},
        // Smallest address, smallest nonzero length, type zero.
        '{'{64'h0, 64'h1, 32'h0}, 1'b0, 1'b0, '0},
        '{'{ALL_ONES_64, 64'h0, ALL_ONES_32}, 1'b1, 1'b1,
          '{64'h0, 64'h1, 32'h0, 1'b1, 1'b0}},
        // Equal addresses must keep their arrival order, and an address
        // with the top bit set must sort above all smaller ones, compared
        // as unsigned.
        '{'{64'h1000, 64'h10, 32'h1}, 1'b0, 1'b0, '0},
        '{'{64'h1000, 64'h20, 32'h2}, 1'b0, 1'b0, '0},
        '{'{64'h0800, 64'h30, 32'h3}, 1'b0, 1'b0, '0},
        '{'{64'h8000_0000_0000_0000, 64'h40, 32'h4}, 1'b0, 1'b0, '0},
        '{'{64'h7FFF_FFFF_FFFF_FFFF, 64'h50, 32'h5}, 1'b0, 1'b0, '0},
        '{'{64'h1000, 64'h60, 32'h6}, 1'b0, 1'b0, '0},
        '{'{64'h0, 64'h70, 32'h7}, 1'b0, 1'b0, '0},
        '{'{ALL_ONES_64, 64'h80, 32'h8}, 1'b0, 1'b0, '0},
        '{'{64'h1000, 64'h90, 32'h9}, 1'b0, 1'b0, '0},
        '{'{64'h0, 64'h0, 32'h0}, 1'b0, 1'b0, '0},
        // Strictly descending addresses: every insert shifts the whole list.
        '{'{64'h5000, 64'h100, 32'hA}, 1'b0, 1'b0, '0},
        '{'{64'h4000, 64'h200, 32'hB}, 1'b0, 1'b0, '0},
        '{'{64'h3000, 64'h300, 32'hC}, 1'b0, 1'b0, '0},
        '{'{64'h2000, 64'h400, 32'hD}, 1'b0, 1'b0, '0},
        '{'{64'h0, 64'h0, 32'h0}, 1'b0, 1'b0, '0},
        // Alternating bit patterns, so each bit toggles in every field.
        '{'{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 32'h5555_5555},
          1'b0, 1'b0, '0},
        '{'{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA},
          1'b0, 1'b0, '0},
        '{'{64'h0, 64'h0, 32'h0}, 1'b0, 1'b0, '0}
    };

    memory_map_entry_sorter_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advances the sorted list by one accepted request. A nonzero length
    // inserts the entry behind every stored entry whose address is not
    // greater, or drops it if the store is full. A zero length releases
    // the whole list into the pending queue (when queue_results is set)
    // and clears the list.
    function automatic void sort_entry(input mmes_pkg::in_req_t req,
                                       input bit queue_results);
        int                 pos;
        mmes_pkg::out_req_t run_entry;
        if (req.region_length != '0) begin
            if (sorted_count >= mmes_pkg::MAX_ENTRIES) begin
                entries_dropped = 1'b1;
            end else begin
                pos = sorted_count;
                while (pos > 0 && req.base_address < sorted_entries[pos-1].base_address) begin
                    sorted_entries[pos] = sorted_entries[pos-1];
                    pos--;
                end
                sorted_entries[pos] = req;
                sorted_count++;
            end
        end else begin
            for (int k = 0; k < sorted_count; k++) begin
                run_entry.out_address = sorted_entries[k].base_address;
                run_entry.out_length  = sorted_entries[k].region_length;
                run_entry.out_type    = sorted_entries[k].region_type;
                run_entry.final_entry = (k == sorted_count - 1);
                run_entry.overflowed  = entries_dropped;
                if (queue_results) begin
                    pending_entries.push_back(run_entry);
                end
            end
            sorted_count    = 0;
            entries_dropped = 1'b0;
        end
    endfunction

    // Random addresses lean on a few small values so that equal addresses
    // show up often; the rest cover the extremes and the full range.
    function automatic logic [63:0] random_address();
        logic [63:0] addr;
        case ($urandom_range(0, 5))
            0: addr = 64'($urandom_range(0, 7)) << 12;
            1: addr = '0;
            2: addr = ALL_ONES_64;
            3: addr = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
            default: addr = {$urandom, $urandom};
        endcase
        return addr;
    endfunction

    function automatic logic [63:0] random_length();
        logic [63:0] len;
        case ($urandom_range(0, 7))
            0: len = 64'h1;
            1: len = ALL_ONES_64;
            default: len = {$urandom, $urandom};
        endcase
        if (len == '0) begin
            len = 64'h1;
        end
        return len;
    endfunction

    // Presents one request and returns at the edge where it is accepted.
    // The sender works in bursts; between bursts valid usually drops for a random
    // gap. Valid is left high after an accepted request so that the next
    // request in the same burst follows with no bubble.
    task automatic send_request(input mmes_pkg::in_req_t req);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                gap        = 0;
                burst_left = $urandom_range(20, 60);
            end else begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 12);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        burst_left--;
    endtask

    // Holds the sender off until every pending result has come out.
    task automatic wait_for_drain();
        s_valid    <= 1'b0;
        burst_left = 0;
        do begin
            @(posedge aclk);
        end while (pending_entries.size() != 0);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] expected_value,
                                   input logic [63:0] actual_value);
        $display("%0t: %s mismatch, expected %h, actual %h",
                 $time, field, expected_value, actual_value);
        error_count++;
    endtask

    // Receiver side. Each stretch picks one stall pattern: always ready,
    // random, a fixed period, or mostly stalled.
    always @(posedge aclk) begin
        static rx_mode_t rx_mode    = RX_STEADY;
        static int       rx_left    = 0;
        static int       rx_counter = 0;
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 64);
        end else begin
            rx_left--;
        end
        rx_counter++;
        case (rx_mode)
            RX_STEADY:   m_ready <= 1'b1;
            RX_RANDOM:   m_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_ready <= (rx_counter % 4 != 3);
            RX_SLOW:     m_ready <= ($urandom_range(0, 3) == 0);
            default:     m_ready <= 1'b1;
        endcase
    end

    // Result checker. Every accepted result is matched against the oldest
    // pending entry of the sorted run.
    always @(posedge aclk) begin
        mmes_pkg::out_req_t expected_entry;
        if (aresetn && m_valid && m_ready) begin
            if (pending_entries.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
                error_count++;
            end else begin
                expected_entry = pending_entries.pop_front();
                if (m_data.out_address !== expected_entry.out_address) begin
                    report_mismatch("out_address", expected_entry.out_address,
                                    m_data.out_address);
                end
                if (m_data.out_length !== expected_entry.out_length) begin
                    report_mismatch("out_length", expected_entry.out_length,
                                    m_data.out_length);
                end
                if (m_data.out_type !== expected_entry.out_type) begin
                    report_mismatch("out_type", 64'(expected_entry.out_type),
                                    64'(m_data.out_type));
                end
                if (m_data.final_entry !== expected_entry.final_entry) begin
                    report_mismatch("final_entry", 64'(expected_entry.final_entry),
                                    64'(m_data.final_entry));
                end
                if (m_data.overflowed !== expected_entry.overflowed) begin
                    report_mismatch("overflowed", 64'(expected_entry.overflowed),
                                    64'(m_data.overflowed));
                end
            end
        end
    end

    // Watchdog. The limit is many times the slowest correct run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("memory_map_entry_sorter_core test failed");
            $finish;
        end
    end

    initial begin
        int                requests_sent;
        int                list_index;
        int                list_length;
        mmes_pkg::in_req_t req;

        // Synchronous reset, held low at the start.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. Rows with a typed-in outcome still advance the
        // predictor so that it stays in step with the block.
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req);
            sort_entry(directed_rows[i].req, !directed_rows[i].known_result);
            if (directed_rows[i].known_result && directed_rows[i].has_result) begin
                pending_entries.push_back(directed_rows[i].typed_result);
            end
        end
        wait_for_drain();

        // Random part: whole lists with random content, each closed by a
        // terminator. The first list fills the store exactly and the second
        // runs past it; after that the list sizes are drawn at random.
        requests_sent = 0;
        list_index    = 0;
        while (requests_sent < RANDOM_REQUESTS) begin
            if (list_index == 0) begin
                list_length = mmes_pkg::MAX_ENTRIES;
            end else if (list_index == 1) begin
                list_length = mmes_pkg::MAX_ENTRIES + 3;
            end else begin
                case ($urandom_range(0, 15))
                    0: list_length = 0;
                    1: list_length = mmes_pkg::MAX_ENTRIES + $urandom_range(1, 4);
                    2: list_length = mmes_pkg::MAX_ENTRIES;
                    default: list_length = $urandom_range(1, 10);
                endcase
            end
            for (int k = 0; k < list_length; k++) begin
                req.base_address  = random_address();
                req.region_length = random_length();
                req.region_type   = $urandom;
                send_request(req);
                sort_entry(req, 1'b1);
                requests_sent++;
            end
            // The terminator's address and type carry random junk.
            req.base_address  = random_address();
            req.region_length = '0;
            req.region_type   = $urandom;
            send_request(req);
            sort_entry(req, 1'b1);
            requests_sent++;
            list_index++;
            if ($urandom_range(0, 9) == 0) begin
                wait_for_drain();
            end
        end

        // Let every pending result come out, then keep watching for anything
        // the block should not be sending.
        wait_for_drain();
        repeat (20) @(posedge aclk);
        if (error_count == 0 && pending_entries.size() == 0) begin
            $display("memory_map_entry_sorter_core test passed");
        end else begin
            $display("memory_map_entry_sorter_core test failed");
        end
        $finish;
    end

endmodule

// ----- memory_map_entry_sorter_core.f -----
rtl/mmes_pkg.sv
rtl/mmes_cell.sv
rtl/memory_map_entry_sorter_core.sv
tb/testbench.sv
